// ===== src/u8dec_pkg.sv =====
// Shared types, codes and constants of the UTF-8 stream decoder.
// No dependencies; every other file refers to this package by scoped names.
package u8dec_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SHORT   = 2'd2;

	// Field widths
	localparam int CP_W   = 21;
	localparam int ST_W   = 2;
	localparam int USED_W = 3;

	// Range checks applied when a sequence completes
	localparam logic [CP_W-1:0] MIN_CP_2  = 21'h00080;
	localparam logic [CP_W-1:0] MIN_CP_3  = 21'h00800;
	localparam logic [CP_W-1:0] MIN_CP_4  = 21'h10000;
	localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
	localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;
	localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

	// Sequence lengths
	localparam logic [USED_W-1:0] LEN_1 = 3'd1;
	localparam logic [USED_W-1:0] LEN_2 = 3'd2;
	localparam logic [USED_W-1:0] LEN_3 = 3'd3;
	localparam logic [USED_W-1:0] LEN_4 = 3'd4;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Class of a byte when taken as a lead byte
	typedef enum logic [2:0] {
		LEAD_ASCII = 3'd0,
		LEAD_2     = 3'd1,
		LEAD_3     = 3'd2,
		LEAD_4     = 3'd3,
		LEAD_BAD   = 3'd4
	} lead_class_t;

	// Classified byte as it travels from front to back
	typedef struct packed {
		lead_class_t cls;
		logic        cont_ok;
		logic [6:0]  lead_bits;
		logic [5:0]  cont_bits;
		logic        last;
	} byte_item_t;

	// Sequence length announced by a lead byte
	function automatic logic [USED_W-1:0] lead_len(lead_class_t cls);
		logic [USED_W-1:0] len;
		case (cls)
			LEAD_ASCII: len = LEN_1;
			LEAD_2:     len = LEN_2;
			LEAD_3:     len = LEN_3;
			LEAD_4:     len = LEN_4;
			default:    len = '0;
		endcase
		return len;
	endfunction

endpackage

// ===== src/u8dec_if.sv =====
// Valid/ready channel interfaces: raw byte input and decoded result output.
// Depends on u8dec_pkg for field widths.
interface u8dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface u8dec_cp_if;
	logic                          valid;
	logic                          ready;
	logic [u8dec_pkg::CP_W-1:0]    code_point;
	logic [u8dec_pkg::ST_W-1:0]    status;
	logic [u8dec_pkg::USED_W-1:0]  bytes_used;

	modport source (output valid, output code_point, output status, output bytes_used,
		input ready);
	modport sink   (input valid, input code_point, input status, input bytes_used,
		output ready);
endinterface

// ===== src/u8dec_front.sv =====
// Front end: accepts raw bytes and classifies them for the back end.
// Depends on u8dec_pkg and u8dec_if.
module u8dec_front (
	u8dec_byte_if.sink            stream,
	input  logic                  q_full,
	output logic                  push,
	output u8dec_pkg::byte_item_t push_item
);

	logic [7:0] b;

	assign b = stream.data_byte;

	// Accept whenever the queue has room
	assign stream.ready = !q_full;
	assign push         = stream.valid && !q_full;

	// Classify the byte both as a lead byte and as a continuation byte
	always_comb begin
		push_item.cont_ok   = (b[7:6] == 2'b10);
		push_item.cont_bits = b[5:0];
		push_item.last      = stream.end_of_buffer;
		if (b[7] == 1'b0) begin
			push_item.cls       = u8dec_pkg::LEAD_ASCII;
			push_item.lead_bits = b[6:0];
		end else if (b[7:5] == 3'b110) begin
			push_item.cls       = u8dec_pkg::LEAD_2;
			push_item.lead_bits = {2'b00, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			push_item.cls       = u8dec_pkg::LEAD_3;
			push_item.lead_bits = {3'b000, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			push_item.cls       = u8dec_pkg::LEAD_4;
			push_item.lead_bits = {4'b0000, b[2:0]};
		end else begin
			push_item.cls       = u8dec_pkg::LEAD_BAD;
			push_item.lead_bits = '0;
		end
	end

endmodule

// ===== src/u8dec_queue.sv =====
// Short FIFO of classified bytes between front and back end.
// Depends on u8dec_pkg.
module u8dec_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  u8dec_pkg::byte_item_t push_item,
	output logic                  full,
	input  logic                  pop,
	output u8dec_pkg::byte_item_t pop_item,
	output logic                  not_empty
);

	u8dec_pkg::byte_item_t              entries_q [u8dec_pkg::QUEUE_DEPTH];
	logic [u8dec_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [u8dec_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [u8dec_pkg::QCNT_W-1:0]       count_q;

	localparam logic [u8dec_pkg::QPTR_W-1:0] LAST_PTR =
		u8dec_pkg::QPTR_W'(u8dec_pkg::QUEUE_DEPTH - 1);
	localparam logic [u8dec_pkg::QCNT_W-1:0] DEPTH_CNT =
		u8dec_pkg::QCNT_W'(u8dec_pkg::QUEUE_DEPTH);

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign pop_item  = entries_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT) else $error("queue count out of range");

endmodule

// ===== src/u8dec_back.sv =====
// Back end: sequence state, completion checks and the result register.
// Depends on u8dec_pkg and u8dec_if.
module u8dec_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  u8dec_pkg::byte_item_t item,
	output logic                  pop,
	u8dec_cp_if.source            result
);

	// Sequence state
	logic [1:0]                        rem_q;
	logic [u8dec_pkg::USED_W-1:0]      len_q;
	logic [u8dec_pkg::CP_W-1:0]        part_q;
	logic                              bad_q;

	// Result register
	logic                              out_valid_q;
	logic [u8dec_pkg::CP_W-1:0]        cp_q;
	logic [u8dec_pkg::ST_W-1:0]        st_q;
	logic [u8dec_pkg::USED_W-1:0]      used_q;

	// Next-state and result logic
	logic                              emit;
	logic [u8dec_pkg::CP_W-1:0]        cp_n;
	logic [u8dec_pkg::ST_W-1:0]        st_n;
	logic [u8dec_pkg::USED_W-1:0]      used_n;
	logic [1:0]                        rem_n;
	logic [u8dec_pkg::USED_W-1:0]      len_n;
	logic [u8dec_pkg::CP_W-1:0]        part_n;
	logic                              bad_n;
	logic [u8dec_pkg::CP_W-1:0]        shifted;
	logic                              bad_fin;
	logic [u8dec_pkg::USED_W-1:0]      new_len;

	// Take an item when the result register is free or being drained
	assign pop = q_valid && (!out_valid_q || result.ready);

	assign shifted = {part_q[u8dec_pkg::CP_W-7:0], item.cont_bits};
	assign new_len = u8dec_pkg::lead_len(item.cls);

	always_comb begin
		emit    = 1'b0;
		cp_n    = '0;
		st_n    = u8dec_pkg::ST_OK;
		used_n  = '0;
		rem_n   = rem_q;
		len_n   = len_q;
		part_n  = part_q;
		bad_n   = bad_q;
		bad_fin = bad_q || !item.cont_ok;
		if (rem_q == 2'd0) begin
			// Lead byte
			case (item.cls)
				u8dec_pkg::LEAD_ASCII: begin
					emit   = 1'b1;
					cp_n   = u8dec_pkg::CP_W'(item.lead_bits);
					used_n = u8dec_pkg::LEN_1;
				end
				u8dec_pkg::LEAD_2, u8dec_pkg::LEAD_3, u8dec_pkg::LEAD_4: begin
					if (item.last) begin
						emit = 1'b1;
						st_n = u8dec_pkg::ST_SHORT;
					end else begin
						len_n  = new_len;
						rem_n  = 2'(new_len - 1'b1);
						part_n = u8dec_pkg::CP_W'(item.lead_bits);
						bad_n  = 1'b0;
					end
				end
				default: begin
					emit = 1'b1;
					st_n = u8dec_pkg::ST_INVALID;
				end
			endcase
		end else begin
			// Continuation byte
			rem_n = rem_q - 2'd1;
			if (rem_n == 2'd0) begin
				emit = 1'b1;
				if (len_q == u8dec_pkg::LEN_2 && shifted < u8dec_pkg::MIN_CP_2) begin
					bad_fin = 1'b1;
				end
				if (len_q == u8dec_pkg::LEN_3 && (shifted < u8dec_pkg::MIN_CP_3 ||
					shifted inside {[u8dec_pkg::SURR_LO:u8dec_pkg::SURR_HI]})) begin
					bad_fin = 1'b1;
				end
				if (len_q == u8dec_pkg::LEN_4 && (shifted < u8dec_pkg::MIN_CP_4 ||
					shifted > u8dec_pkg::MAX_CP)) begin
					bad_fin = 1'b1;
				end
				if (bad_fin) begin
					st_n = u8dec_pkg::ST_INVALID;
				end else begin
					cp_n   = shifted;
					used_n = len_q;
				end
			end else if (item.last) begin
				emit  = 1'b1;
				st_n  = u8dec_pkg::ST_SHORT;
				rem_n = 2'd0;
			end else begin
				part_n = shifted;
				bad_n  = bad_fin;
			end
		end
	end

	// Advance the sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			len_q <= '0;
			bad_q <= 1'b0;
		end else if (pop) begin
			rem_q <= rem_n;
			len_q <= len_n;
			bad_q <= bad_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			part_q <= part_n;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			cp_q   <= cp_n;
			st_q   <= st_n;
			used_q <= used_n;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.code_point = cp_q;
	assign result.status     = st_q;
	assign result.bytes_used = used_q;

	a_rem_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 2'd0 |-> ({1'b0, rem_q} < len_q && len_q >= u8dec_pkg::LEN_2))
		else $error("remaining count inconsistent with sequence length");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && st_q != u8dec_pkg::ST_OK |-> cp_q == '0 && used_q == '0)
		else $error("error result carries data");
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && st_q == u8dec_pkg::ST_OK |->
		used_q != '0 && used_q <= u8dec_pkg::LEN_4 && cp_q <= u8dec_pkg::MAX_CP)
		else $error("success result out of range");
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_valid_q || result.ready)
		else $error("item taken while result register is blocked");

endmodule

// ===== src/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder top level: front classifier, item queue, back decoder.
// Depends on u8dec_pkg, u8dec_if, u8dec_front, u8dec_queue, u8dec_back.
//
// The decoder takes one byte per cycle on the stream channel while the result
// channel is not stalled and delivers one result per completed sequence,
// invalid lead byte or early end of buffer on the result channel. A byte
// accepted on the stream channel is classified into a two-entry queue; the
// back end reads it from the queue and the result, if any, is registered in
// the result register as the byte is taken. Throughput is set by the back end's
// per-byte update of the sequence state, one byte per cycle; a stalled result
// channel backs up through the queue to the stream's ready. No reset sweep is
// needed: the block accepts bytes as soon as reset is released.
module utf8_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	u8dec_byte_if.sink  stream,
	u8dec_cp_if.source  result
);

	logic                  push;
	logic                  q_full;
	logic                  q_valid;
	logic                  pop;
	u8dec_pkg::byte_item_t push_item;
	u8dec_pkg::byte_item_t pop_item;

	u8dec_front u_front (
		.stream    (stream),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	u8dec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_valid)
	);

	u8dec_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.item    (pop_item),
		.pop     (pop),
		.result  (result)
	);

endmodule
